>>> design/hcvt_pkg.sv
// ----------------------------------------------------------------------------
// Hollow cylinder voxel test package
// Shared widths, register indexes, reject codes and the stage records that
// travel down the pipeline.
// ----------------------------------------------------------------------------
package hcvt_pkg;

  // Width of every coordinate and radius.
  localparam int COORD_BITS = 10;

  // Signed difference of two coordinates.
  localparam int DIFF_W   = COORD_BITS + 1;
  // Signed product of two differences, and the cross product components.
  localparam int PROD_W   = 2 * DIFF_W;
  // Square of a difference or of a radius.
  localparam int SQ1_W    = 2 * COORD_BITS;
  // Sum of three squares (squared lengths).
  localparam int SUM_W    = SQ1_W + 2;
  // Radius squared plus squared axis length.
  localparam int HYP_W    = SUM_W + 1;
  // Square of one cross product component.
  localparam int XSQ_W    = 2 * PROD_W - 2;
  // Radius squared times squared axis length.
  localparam int LIM_W    = SQ1_W + SUM_W;
  // Squared norm of the cross product.
  localparam int CROSS2_W = XSQ_W + 2;

  localparam int REASON_W    = 3;
  localparam int IN_TDATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((1 + REASON_W + 7) / 8) * 8;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_START_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_END_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_END_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_END_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 3'd7;

  // Reject codes.
  localparam logic [REASON_W-1:0] REASON_INSIDE = 3'd0;
  localparam logic [REASON_W-1:0] REASON_OUTER  = 3'd1;
  localparam logic [REASON_W-1:0] REASON_INNER  = 3'd2;
  localparam logic [REASON_W-1:0] REASON_LENGTH = 3'd3;
  localparam logic [REASON_W-1:0] REASON_DEGEN  = 3'd4;

  typedef struct packed {
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] az;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
    logic [COORD_BITS-1:0] bz;
    logic [COORD_BITS-1:0] rin;
    logic [COORD_BITS-1:0] rout;
  } tube_cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } point_t;

  // Axis vector u = B - A, v = P - A, w = P - B.
  typedef struct packed {
    logic signed [DIFF_W-1:0] ux;
    logic signed [DIFF_W-1:0] uy;
    logic signed [DIFF_W-1:0] uz;
    logic signed [DIFF_W-1:0] vx;
    logic signed [DIFF_W-1:0] vy;
    logic signed [DIFF_W-1:0] vz;
    logic signed [DIFF_W-1:0] wx;
    logic signed [DIFF_W-1:0] wy;
    logic signed [DIFF_W-1:0] wz;
  } diff_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] pyz;
    logic signed [PROD_W-1:0] pzy;
    logic signed [PROD_W-1:0] pzx;
    logic signed [PROD_W-1:0] pxz;
    logic signed [PROD_W-1:0] pxy;
    logic signed [PROD_W-1:0] pyx;
    logic [SQ1_W-1:0]         ux2;
    logic [SQ1_W-1:0]         uy2;
    logic [SQ1_W-1:0]         uz2;
    logic [SQ1_W-1:0]         vx2;
    logic [SQ1_W-1:0]         vy2;
    logic [SQ1_W-1:0]         vz2;
    logic [SQ1_W-1:0]         wx2;
    logic [SQ1_W-1:0]         wy2;
    logic [SQ1_W-1:0]         wz2;
    logic [SQ1_W-1:0]         rout2;
    logic [SQ1_W-1:0]         rin2;
  } prod_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] cx;
    logic signed [PROD_W-1:0] cy;
    logic signed [PROD_W-1:0] cz;
    logic [SUM_W-1:0]         len2;
    logic [SUM_W-1:0]         da;
    logic [SUM_W-1:0]         db;
    logic [SQ1_W-1:0]         rout2;
    logic [SQ1_W-1:0]         rin2;
  } sum_t;

  typedef struct packed {
    logic [XSQ_W-1:0] cx2;
    logic [XSQ_W-1:0] cy2;
    logic [XSQ_W-1:0] cz2;
    logic [LIM_W-1:0] lim_out;
    logic [LIM_W-1:0] lim_in;
    logic             degen;
    logic             len_fail;
  } sq_t;

  typedef struct packed {
    logic                inside_res;
    logic [REASON_W-1:0] reject_reason;
  } result_t;

  // Square of a coordinate difference; the magnitude is below 2**COORD_BITS.
  function automatic logic [SQ1_W-1:0] sq_diff(input logic signed [DIFF_W-1:0] d);
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(d) * PROD_W'(d);
    return p[SQ1_W-1:0];
  endfunction

  // Square of one cross product component. The magnitude of a component stays
  // below 2**(PROD_W-1), so an unsigned square of the magnitude is exact.
  function automatic logic [XSQ_W-1:0] sq_cross(input logic signed [PROD_W-1:0] c);
    logic [PROD_W-1:0] a;
    a = c[PROD_W-1] ? -c : c;
    return XSQ_W'(a[PROD_W-2:0]) * XSQ_W'(a[PROD_W-2:0]);
  endfunction

endpackage

>>> design/hollow_cylinder_voxel_test.sv
// ----------------------------------------------------------------------------
// Hollow cylinder voxel test
// Throughput: one item per cycle; the five-stage pipeline holds up to five
// items, each stage moving on whenever the stage after it is free.
// Reset (rst, synchronous, active high) empties the pipeline and clears all
// configuration registers to zero.
// ----------------------------------------------------------------------------
module hollow_cylinder_voxel_test import hcvt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,

  // Configuration write channel. Register index i selects the register in
  // the order axis start x/y/z, axis end x/y/z, inner radius, outer radius.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]  cfg_data,

  // Input items. s_tdata fields from bit 0 up: point_x, point_y, point_z,
  // then zero padding.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,

  // Result items. m_tdata fields from bit 0 up: inside_res, reject_reason,
  // then zero padding.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // The configuration registers must only change while the pipeline is empty
  // (the block does not check). Stages 1 and 2 read them and hold no copies.
  tube_cfg_t cfg;

  point_t  pt;
  diff_t   diff_data;
  prod_t   prod_data;
  sq_t     sq_data;
  result_t res;

  logic diff_valid;
  logic diff_ready;
  logic prod_valid;
  logic prod_ready;
  logic sq_valid;
  logic sq_ready;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AXIS_START_X: cfg.ax   <= cfg_data;
        REG_AXIS_START_Y: cfg.ay   <= cfg_data;
        REG_AXIS_START_Z: cfg.az   <= cfg_data;
        REG_AXIS_END_X:   cfg.bx   <= cfg_data;
        REG_AXIS_END_Y:   cfg.by   <= cfg_data;
        REG_AXIS_END_Z:   cfg.bz   <= cfg_data;
        REG_INNER_RADIUS: cfg.rin  <= cfg_data;
        REG_OUTER_RADIUS: cfg.rout <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the voxel coordinate; padding bits above the three fields are
  // ignored.
  assign pt.x = s_tdata[COORD_BITS-1:0];
  assign pt.y = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign pt.z = s_tdata[3*COORD_BITS-1:2*COORD_BITS];

  // Stage 1: differences against both axis ends.
  hcvt_diff u_diff (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .pt        (pt),
    .out_valid (diff_valid),
    .out_ready (diff_ready),
    .out_data  (diff_data)
  );

  // Stage 2: narrow products and squares.
  hcvt_prod u_prod (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (diff_valid),
    .in_ready  (diff_ready),
    .in_data   (diff_data),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  // Stages 3 and 4: cross product, its square, the radius limits and the
  // far-end length test.
  hcvt_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_data  (sq_data)
  );

  // Stage 5: final compares; its register is the output register.
  hcvt_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_data   (sq_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {(OUT_TDATA_W - 1 - REASON_W)'(0), res.reject_reason, res.inside_res};

  // The inside flag and the reject code must always agree.
  a_inside_matches_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.inside_res == (res.reject_reason == REASON_INSIDE)))
    else $error("inside flag disagrees with reject code");

  // Only the five defined reject codes may leave the block.
  a_code_defined: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.reject_reason <= REASON_DEGEN))
    else $error("undefined reject code on output");

  // A free output side lets the whole pipeline advance.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output is ready");

  // With the output side ready throughout, an accepted item reaches the output.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
      |=> m_tvalid)
    else $error("result missing after pipeline latency");

endmodule

>>> design/hcvt_diff.sv
// ----------------------------------------------------------------------------
// Hollow cylinder voxel test, difference stage
// Forms the axis vector and the vectors from both axis ends to the voxel.
// ----------------------------------------------------------------------------
module hcvt_diff import hcvt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  tube_cfg_t cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  point_t    pt,
  output logic      out_valid,
  input  logic      out_ready,
  output diff_t     out_data
);

  diff_t diff_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    diff_next.ux = DIFF_W'(cfg.bx) - DIFF_W'(cfg.ax);
    diff_next.uy = DIFF_W'(cfg.by) - DIFF_W'(cfg.ay);
    diff_next.uz = DIFF_W'(cfg.bz) - DIFF_W'(cfg.az);
    diff_next.vx = DIFF_W'(pt.x) - DIFF_W'(cfg.ax);
    diff_next.vy = DIFF_W'(pt.y) - DIFF_W'(cfg.ay);
    diff_next.vz = DIFF_W'(pt.z) - DIFF_W'(cfg.az);
    diff_next.wx = DIFF_W'(pt.x) - DIFF_W'(cfg.bx);
    diff_next.wy = DIFF_W'(pt.y) - DIFF_W'(cfg.by);
    diff_next.wz = DIFF_W'(pt.z) - DIFF_W'(cfg.bz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= diff_next;
    end
  end

endmodule

>>> design/hcvt_prod.sv
// ----------------------------------------------------------------------------
// Hollow cylinder voxel test, product stage
// All narrow products: cross product terms, squared components and radii.
// ----------------------------------------------------------------------------
module hcvt_prod import hcvt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  tube_cfg_t cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  diff_t     in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output prod_t     out_data
);

  prod_t            prod_next;
  logic [SQ1_W-1:0] rout_ext;
  logic [SQ1_W-1:0] rin_ext;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    rout_ext = SQ1_W'(cfg.rout);
    rin_ext  = SQ1_W'(cfg.rin);
    prod_next.pyz   = PROD_W'(in_data.uy) * PROD_W'(in_data.vz);
    prod_next.pzy   = PROD_W'(in_data.uz) * PROD_W'(in_data.vy);
    prod_next.pzx   = PROD_W'(in_data.uz) * PROD_W'(in_data.vx);
    prod_next.pxz   = PROD_W'(in_data.ux) * PROD_W'(in_data.vz);
    prod_next.pxy   = PROD_W'(in_data.ux) * PROD_W'(in_data.vy);
    prod_next.pyx   = PROD_W'(in_data.uy) * PROD_W'(in_data.vx);
    prod_next.ux2   = sq_diff(in_data.ux);
    prod_next.uy2   = sq_diff(in_data.uy);
    prod_next.uz2   = sq_diff(in_data.uz);
    prod_next.vx2   = sq_diff(in_data.vx);
    prod_next.vy2   = sq_diff(in_data.vy);
    prod_next.vz2   = sq_diff(in_data.vz);
    prod_next.wx2   = sq_diff(in_data.wx);
    prod_next.wy2   = sq_diff(in_data.wy);
    prod_next.wz2   = sq_diff(in_data.wz);
    prod_next.rout2 = rout_ext * rout_ext;
    prod_next.rin2  = rin_ext * rin_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= prod_next;
    end
  end

endmodule

>>> design/hcvt_cross.sv
// ----------------------------------------------------------------------------
// Hollow cylinder voxel test, cross product stages
// First stage sums the cross product and squared lengths; the second squares
// the cross product, scales the radii by the axis length and runs the
// length test.
// ----------------------------------------------------------------------------
module hcvt_cross import hcvt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  prod_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output sq_t   out_data
);

  sum_t             sum;
  sum_t             sum_next;
  logic             sum_valid;
  logic             sum_ready;
  sq_t              sq_next;
  logic [SUM_W-1:0] dfar;
  logic [HYP_W-1:0] hyp;

  assign sum_ready = !out_valid || out_ready;
  assign in_ready  = !sum_valid || sum_ready;

  always_comb begin
    sum_next.cx    = in_data.pyz - in_data.pzy;
    sum_next.cy    = in_data.pzx - in_data.pxz;
    sum_next.cz    = in_data.pxy - in_data.pyx;
    sum_next.len2  = SUM_W'(in_data.ux2) + SUM_W'(in_data.uy2) + SUM_W'(in_data.uz2);
    sum_next.da    = SUM_W'(in_data.vx2) + SUM_W'(in_data.vy2) + SUM_W'(in_data.vz2);
    sum_next.db    = SUM_W'(in_data.wx2) + SUM_W'(in_data.wy2) + SUM_W'(in_data.wz2);
    sum_next.rout2 = in_data.rout2;
    sum_next.rin2  = in_data.rin2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (in_ready) begin
      sum_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sum <= sum_next;
    end
  end

  always_comb begin
    dfar = (sum.da > sum.db) ? sum.da : sum.db;
    hyp  = HYP_W'(sum.rout2) + HYP_W'(sum.len2);
    sq_next.cx2      = sq_cross(sum.cx);
    sq_next.cy2      = sq_cross(sum.cy);
    sq_next.cz2      = sq_cross(sum.cz);
    sq_next.lim_out  = LIM_W'(sum.rout2) * LIM_W'(sum.len2);
    sq_next.lim_in   = LIM_W'(sum.rin2) * LIM_W'(sum.len2);
    sq_next.degen    = (sum.len2 == '0);
    sq_next.len_fail = HYP_W'(dfar) > hyp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sum_ready) begin
      out_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && sum_valid) begin
      out_data <= sq_next;
    end
  end

endmodule

>>> design/hcvt_decide.sv
// ----------------------------------------------------------------------------
// Hollow cylinder voxel test, decision stage
// Adds up the squared cross product, compares it against both radius limits
// and holds the result for the output side.
// ----------------------------------------------------------------------------
module hcvt_decide import hcvt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  sq_t     in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic [CROSS2_W-1:0] cross2;
  result_t             res_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    cross2 = CROSS2_W'(in_data.cx2) + CROSS2_W'(in_data.cy2) + CROSS2_W'(in_data.cz2);
    // Tests in order of precedence; the first failing one names the reason.
    if (in_data.degen) begin
      res_next.reject_reason = REASON_DEGEN;
    end else if (cross2 > CROSS2_W'(in_data.lim_out)) begin
      res_next.reject_reason = REASON_OUTER;
    end else if (cross2 < CROSS2_W'(in_data.lim_in)) begin
      res_next.reject_reason = REASON_INNER;
    end else if (in_data.len_fail) begin
      res_next.reject_reason = REASON_LENGTH;
    end else begin
      res_next.reject_reason = REASON_INSIDE;
    end
    res_next.inside_res = (res_next.reject_reason == REASON_INSIDE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res_next;
    end
  end

endmodule
